FILE: sv/oult_pkg.sv
`default_nettype none

package oult_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 7;

  // Default list depth.
  localparam int unsigned DEF_CAPACITY = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET       = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_INS_AT    = 3'd3,
    CMD_DELETE    = 3'd4,
    CMD_FIND      = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Memory read address source.
  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_POS  = 2'd1,
    RD_PREV = 2'd2,
    RD_NEXT = 2'd3
  } rd_sel_e;

  // Source of the read_value field of a result.
  typedef enum logic [1:0] {
    RV_ZERO = 2'd0,
    RV_NEG1 = 2'd1,
    RV_MEM  = 2'd2
  } rv_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GET_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DEL_RD,
    S_DEL_WR
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      entry_count;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    idx_zero;
    logic    idx_count;
    logic    idx_pos;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    fin;
    status_e fin_status;
    logic    fin_found;
    rv_sel_e fin_rv;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             pos_lt_count;
    logic             idx_lt_count;
    logic             match;
    logic             tgt_gt_count;
    logic             full;
    logic             idx_gt_tgt;
    logic             next_lt_count;
  } stat_t;

endpackage

`default_nettype wire

FILE: sv/oult_ctrl.sv
`default_nettype none

module oult_ctrl
  import oult_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  state_e state_r;
  state_e state_nxt;
  logic   is_find;

  assign is_find = (stat.cmd == CMD_FIND);
  assign busy    = (state_r != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_GET:    state_nxt = stat.pos_lt_count ? S_GET_WAIT : S_IDLE;
          CMD_DELETE: state_nxt = stat.pos_lt_count ? S_DEL_RD : S_IDLE;
          CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT, CMD_FIND: state_nxt = S_SCAN_RD;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_GET_WAIT: state_nxt = S_IDLE;
      S_SCAN_RD: begin
        if (stat.idx_lt_count) begin
          state_nxt = S_SCAN_CMP;
        end else begin
          state_nxt = is_find ? S_IDLE : S_INS_CHECK;
        end
      end
      S_SCAN_CMP: state_nxt = stat.match ? S_IDLE : S_SCAN_RD;
      S_INS_CHECK: begin
        if (stat.tgt_gt_count || stat.full) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_nxt = stat.idx_gt_tgt ? S_SHIFT_WR : S_IDLE;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_DEL_RD:   state_nxt = stat.next_lt_count ? S_DEL_WR : S_IDLE;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl            = '0;
    ctrl.rd_sel     = RD_IDX;
    ctrl.fin_status = ST_OK;
    ctrl.fin_rv     = RV_ZERO;
    case (state_r)
      S_IDLE: begin
        ctrl.load = start;
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_GET: begin
            if (stat.pos_lt_count) begin
              ctrl.rd_en  = 1'b1;
              ctrl.rd_sel = RD_POS;
            end else begin
              ctrl.fin        = 1'b1;
              ctrl.fin_status = ST_BADPOS;
              ctrl.fin_rv     = RV_NEG1;
            end
          end
          CMD_DELETE: begin
            if (stat.pos_lt_count) begin
              ctrl.idx_pos = 1'b1;
            end else begin
              ctrl.fin        = 1'b1;
              ctrl.fin_status = ST_BADPOS;
            end
          end
          CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT, CMD_FIND: ctrl.idx_zero = 1'b1;
          default: ctrl.fin = 1'b1;
        endcase
      end
      S_GET_WAIT: begin
        ctrl.fin    = 1'b1;
        ctrl.fin_rv = RV_MEM;
      end
      S_SCAN_RD: begin
        if (stat.idx_lt_count) begin
          ctrl.rd_en = 1'b1;
        end else if (is_find) begin
          ctrl.fin = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          ctrl.fin        = 1'b1;
          ctrl.fin_found  = is_find;
          ctrl.fin_status = is_find ? ST_OK : ST_DUP;
        end else begin
          ctrl.idx_inc = 1'b1;
        end
      end
      S_INS_CHECK: begin
        if (stat.tgt_gt_count) begin
          ctrl.fin        = 1'b1;
          ctrl.fin_status = ST_BADPOS;
        end else if (stat.full) begin
          ctrl.fin        = 1'b1;
          ctrl.fin_status = ST_FULL;
        end else begin
          ctrl.idx_count = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (stat.idx_gt_tgt) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_PREV;
        end else begin
          // The hole is open at the target position: place the new word.
          ctrl.wr_en   = 1'b1;
          ctrl.wr_val  = 1'b1;
          ctrl.cnt_inc = 1'b1;
          ctrl.fin     = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.idx_dec = 1'b1;
      end
      S_DEL_RD: begin
        if (stat.next_lt_count) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = RD_NEXT;
        end else begin
          ctrl.cnt_dec = 1'b1;
          ctrl.fin     = 1'b1;
        end
      end
      S_DEL_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.idx_inc = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/oult_datapath.sv
`default_nettype none

module oult_datapath
  import oult_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
)
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_word,
  input  wire ctrl_t    ctrl,
  output stat_t         stat,
  output logic          out_valid,
  output out_word_t     out_word
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     idx_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  rdata_r;
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic [CMPW-1:0]   count_x;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   idx_x;
  logic [CMPW-1:0]   tgt_x;
  logic [CMPW-1:0]   count_nxt_x;
  logic [CW:0]       idx_p1;
  logic [CW-1:0]     rd_addr;
  logic [VAL_W-1:0]  wr_data;

  assign count_x     = CMPW'(count_r);
  assign pos_x       = CMPW'(pos_r);
  assign idx_x       = CMPW'(idx_r);
  assign idx_p1      = {1'b0, idx_r} + (CW+1)'(1);
  assign count_nxt_x = CMPW'(count_nxt);

  // Insert position for each insert command.
  always_comb begin
    case (cmd_r)
      CMD_INS_FRONT: tgt_x = '0;
      CMD_INS_BACK:  tgt_x = count_x;
      default:       tgt_x = pos_x;
    endcase
  end

  // Status to the controller.
  always_comb begin
    stat.cmd           = cmd_r;
    stat.pos_lt_count  = (pos_x < count_x);
    stat.idx_lt_count  = (idx_r < count_r);
    stat.match         = (rdata_r == val_r);
    stat.tgt_gt_count  = (tgt_x > count_x);
    stat.full          = (count_r == CW'(CAPACITY));
    stat.idx_gt_tgt    = (idx_x > tgt_x);
    stat.next_lt_count = (idx_p1 < {1'b0, count_r});
  end

  // Command word capture.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_word.command;
      pos_r <= in_word.position;
      val_r <= in_word.item_value;
    end
  end

  // Walk index.
  always_ff @(posedge clk) begin
    if (ctrl.idx_zero) begin
      idx_r <= '0;
    end else if (ctrl.idx_count) begin
      idx_r <= count_r;
    end else if (ctrl.idx_pos) begin
      idx_r <= pos_x[CW-1:0];
    end else if (ctrl.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end else if (ctrl.idx_dec) begin
      idx_r <= idx_r - CW'(1);
    end
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Entry memory: one read port with registered data, one write port at the walk index.
  always_comb begin
    case (ctrl.rd_sel)
      RD_POS:  rd_addr = pos_x[CW-1:0];
      RD_PREV: rd_addr = idx_r - CW'(1);
      RD_NEXT: rd_addr = idx_p1[CW-1:0];
      default: rd_addr = idx_r;
    endcase
  end

  assign wr_data = ctrl.wr_val ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[idx_r[AW-1:0]] <= wr_data;
    end
  end

  // Result word and strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      case (ctrl.fin_rv)
        RV_NEG1: out_word_r.read_value <= '1;
        RV_MEM:  out_word_r.read_value <= rdata_r;
        default: out_word_r.read_value <= '0;
      endcase
      out_word_r.found       <= ctrl.fin_found;
      out_word_r.status      <= ctrl.fin_status;
      out_word_r.entry_count <= count_nxt_x[COUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: sv/ordered_unique_list_table_core.sv
`default_nettype none

// Bounded ordered list of unique 32-bit values held in one single-port-read,
// single-port-write memory of CAPACITY words. A command word is taken when
// start is high and busy is low; exactly one result word follows, shown on
// out_word for one cycle while out_valid is high, and the receiver cannot
// stall it. Commands run one at a time and their length depends on the list:
// get reads the entry at its position and shows it from a wait state, an
// out-of-range get or delete ends at dispatch, find and the duplicate
// check of every insert walk the stored entries with a read and a compare
// state per entry, an insert then moves each entry behind the insert point
// and a delete each entry behind the deleted one with a read and a write
// state per entry. The walks are paced by the one memory read port, whose
// registered data must return before a compare or a copy. busy drops in
// the cycle the result is shown, so the next command may be taken then.
// Entries above the stored count are never read, so the memory needs no
// clearing after reset.
module ordered_unique_list_table_core
  import oult_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
)
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer.
  oult_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // List storage, walk index and result register.
  oult_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // An accepted word always starts a command.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // A result is shown only once the command has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A found flag only comes with a clean status and no read data.
  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.found) |->
      (out_word.status == ST_OK && out_word.read_value == '0))
    else $error("found set with bad status or read data");
`endif

endmodule

`default_nettype wire

FILE: sim/oult_list_checker.sv
`default_nettype none

// Watches both channels of the list table, keeps its own copy of the list,
// predicts the result word of every accepted command word and compares each
// result word with the oldest prediction.
module oult_list_checker
  import oult_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire in_word_t  in_word,
  input  wire logic      out_valid,
  input  wire out_word_t out_word,
  input  wire logic      drained,
  output int             fail_count,
  output int             outstanding
);

  // Shadow copy of the list and its length.
  logic [VAL_W-1:0] shadow_list [0:CAPACITY-1];
  int               shadow_len;

  // Predicted result words, oldest first.
  out_word_t        pending_replies [$];
  bit               leftovers_checked;

  // Looks for a value among the stored entries.
  function automatic bit list_holds(logic [VAL_W-1:0] v);
    int i;
    for (i = 0; i < shadow_len; i++) begin
      if (shadow_list[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Inserts a value at a list position; the duplicate check comes first,
  // then the position check, then the capacity check.
  function automatic status_e insert_value(int at, logic [VAL_W-1:0] v);
    int i;
    if (list_holds(v)) return ST_DUP;
    if (at > shadow_len) return ST_BADPOS;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (i = shadow_len; i > at; i--) begin
      shadow_list[i] = shadow_list[i-1];
    end
    shadow_list[at] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  // Applies one command word to the shadow list and returns its result word.
  function automatic out_word_t compute_reply(in_word_t w);
    out_word_t r;
    int        p;
    int        i;
    r = '0;
    p = int'(w.position);
    r.status = ST_OK;
    case (w.command)
      CMD_GET: begin
        if (p < shadow_len) begin
          r.read_value = shadow_list[p];
        end else begin
          r.read_value = -1;
          r.status     = ST_BADPOS;
        end
      end
      CMD_INS_FRONT: r.status = insert_value(0, w.item_value);
      CMD_INS_BACK:  r.status = insert_value(shadow_len, w.item_value);
      CMD_INS_AT:    r.status = insert_value(p, w.item_value);
      CMD_DELETE: begin
        if (p < shadow_len) begin
          for (i = p; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i+1];
          end
          shadow_len--;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      CMD_FIND: r.found = list_holds(w.item_value);
      // Unused command codes change nothing and report zeros but for the entry count.
      default: ;
    endcase
    r.entry_count = COUNT_W'(shadow_len);
    return r;
  endfunction

  // Prints one field mismatch.
  function automatic int report_field(string field, logic [VAL_W-1:0] exp_v,
                                      logic [VAL_W-1:0] act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: mismatch in %s: expected 0x%08h, actual 0x%08h",
             $time, field, exp_v, act_v);
    return 1;
  endfunction

  // Result words are checked before the command word of the same edge is
  // predicted, since that word's result always comes later.
  always @(posedge clk) begin
    out_word_t exp_w;
    int        n_err;
    n_err = 0;
    if (!rst_n) begin
      pending_replies.delete();
      shadow_len        = 0;
      leftovers_checked = 1'b0;
      outstanding      <= 0;
      fail_count       <= 0;
    end else begin
      if (out_valid) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result word with nothing expected: expected none, actual 0x%h",
                   $time, out_word);
          n_err++;
        end else begin
          exp_w = pending_replies.pop_front();
          n_err += report_field("read_value", exp_w.read_value, out_word.read_value);
          n_err += report_field("found", VAL_W'(exp_w.found), VAL_W'(out_word.found));
          n_err += report_field("status", VAL_W'(exp_w.status), VAL_W'(out_word.status));
          n_err += report_field("entry_count", VAL_W'(exp_w.entry_count),
                                VAL_W'(out_word.entry_count));
        end
      end
      if (start && !busy) begin
        pending_replies.push_back(compute_reply(in_word));
      end
      if (drained && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_replies.size() != 0) begin
          $display("%0t: results never arrived: expected 0, actual %0d still waiting",
                   $time, pending_replies.size());
          n_err += pending_replies.size();
        end
      end
      outstanding <= pending_replies.size();
      fail_count  <= fail_count + n_err;
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_ordered_unique_list_table_core.sv
`default_nettype none

module tb_ordered_unique_list_table_core;
  import oult_pkg::*;

  localparam int CAPACITY   = DEF_CAPACITY;
  localparam int RAND_WORDS = 1500;
  localparam int DRAIN_WAIT = 600;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;
  logic      drained = 1'b0;
  int        fail_count;
  int        outstanding;

  // Recently used values, so that duplicates and find hits are common.
  logic [VAL_W-1:0] value_pool [0:31];
  bit               gaps_on;

  ordered_unique_list_table_core #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  oult_list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .drained     (drained),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #12000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_word_t make_word(logic [CMD_W-1:0] c, int p, logic [VAL_W-1:0] v);
    in_word_t w;
    w.command    = c;
    w.position   = POS_W'(p);
    w.item_value = v;
    return w;
  endfunction

  // Presents one command word and holds it until it is taken. start stays
  // high afterwards, so a back-to-back word needs no second assignment.
  task automatic send_word(in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  // Random gap between words, mostly short and a few long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start   <= 1'b0;
      in_word <= make_word(3'($urandom), $urandom, $urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the sender off until every result word has come back.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return value_pool[$urandom_range(0, 31)];
    return $urandom;
  endfunction

  function automatic int pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 64);
    if (r < 92) return $urandom_range(0, 7);
    return $urandom_range(65, 127);
  endfunction

  // Builds one random command word; the mode biases the list toward
  // filling up, draining or staying put.
  function automatic in_word_t random_word(int mode);
    int               r;
    logic [VAL_W-1:0] v;
    logic [CMD_W-1:0] c;
    int               p;
    r = $urandom_range(0, 99);
    v = pick_value();
    p = pick_pos();
    if (r >= 97) begin
      c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    end else if (mode == MODE_GROW) begin
      if (r < 30) c = CMD_INS_FRONT;
      else if (r < 60) c = CMD_INS_BACK;
      else if (r < 75) c = CMD_INS_AT;
      else if (r < 80) c = CMD_DELETE;
      else if (r < 88) c = CMD_GET;
      else c = CMD_FIND;
    end else if (mode == MODE_SHRINK) begin
      if (r < 45) begin
        c = CMD_DELETE;
        p = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : p;
      end else if (r < 50) c = CMD_INS_FRONT;
      else if (r < 55) c = CMD_INS_AT;
      else if (r < 75) c = CMD_GET;
      else c = CMD_FIND;
    end else begin
      if (r < 12) c = CMD_INS_FRONT;
      else if (r < 24) c = CMD_INS_BACK;
      else if (r < 40) c = CMD_INS_AT;
      else if (r < 60) c = CMD_DELETE;
      else if (r < 80) c = CMD_GET;
      else c = CMD_FIND;
    end
    return make_word(c, p, v);
  endfunction

  initial begin
    int sent;
    int phase_len;
    int mode;
    int i;
    in_word_t w;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'hFFFF_FFFF;
    value_pool[3] = 32'h0000_0000;
    for (i = 4; i < 32; i++) value_pool[i] = $urandom;
    gaps_on = 1'b1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: empty-list refusals, the value extremes, duplicates,
    // bad positions for every positional command, append at the list end
    // and the unused command codes.
    send_word(make_word(CMD_GET, 0, 32'd0));
    send_word(make_word(CMD_DELETE, 0, 32'd0));
    send_word(make_word(CMD_FIND, 0, 32'd0));
    send_word(make_word(CMD_INS_AT, 1, 32'd9));
    send_word(make_word(CMD_INS_FRONT, 127, 32'h8000_0000));
    send_word(make_word(CMD_INS_BACK, 127, 32'h7FFF_FFFF));
    send_word(make_word(CMD_INS_FRONT, 0, 32'h7FFF_FFFF));
    send_word(make_word(CMD_INS_AT, 1, 32'hFFFF_FFFF));
    send_word(make_word(CMD_INS_AT, 3, 32'h0000_0000));
    send_word(make_word(CMD_INS_AT, 127, 32'd5));
    send_word(make_word(CMD_INS_AT, 127, 32'h8000_0000));
    send_word(make_word(CMD_INS_BACK, 0, 32'd0));
    send_word(make_word(CMD_GET, 0, 32'd0));
    send_word(make_word(CMD_GET, 3, 32'd0));
    send_word(make_word(CMD_GET, 4, 32'd0));
    send_word(make_word(CMD_GET, 127, 32'd0));
    send_word(make_word(CMD_FIND, 0, 32'hFFFF_FFFF));
    send_word(make_word(CMD_FIND, 0, 32'd12345));
    send_word(make_word(CMD_DELETE, 1, 32'd0));
    send_word(make_word(CMD_DELETE, 127, 32'd0));
    send_word(make_word(CMD_SPARE_A, 127, 32'hFFFF_FFFF));
    send_word(make_word(CMD_SPARE_B, 0, 32'h8000_0000));
    send_word(make_word(CMD_DELETE, 0, 32'd0));
    send_word(make_word(CMD_GET, 0, 32'd0));
    wait_quiet();

    // Random phases that fill the list past capacity, drain it and mix.
    sent = 0;
    while (sent < RAND_WORDS) begin
      phase_len = $urandom_range(40, 160);
      mode      = $urandom_range(MODE_GROW, MODE_MIXED);
      gaps_on   = ($urandom_range(0, 3) != 0);
      for (i = 0; i < phase_len && sent < RAND_WORDS; i++) begin
        w = random_word(mode);
        if ($urandom_range(0, 1) != 0) value_pool[$urandom_range(0, 31)] = w.item_value;
        send_word(w);
        sent++;
        idle_gap();
      end
      if ($urandom_range(0, 2) == 0) wait_quiet();
    end

    // Let every result word arrive, then watch for strays.
    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
